@@ rtl/core/bitmap_font_text_renderer_top_macros.svh @@
// Assertion macros for the bitmap font text renderer checker
`ifndef BITMAP_FONT_TEXT_RENDERER_TOP_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_TOP_MACROS_SVH

// Check a consequence in the cycle after an antecedent, outside reset
`define BFTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check the state in the cycle after reset is applied
`define BFTR_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bftr_pkg.sv @@
// Shared types and constants of the bitmap font text renderer
`default_nettype none

package bftr_pkg;

  localparam int DEF_GLYPH_ROWS = 16;
  localparam int DEF_FONT_DEPTH = 4096;
  localparam int FONT_ADDR_W    = 12;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 13;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd130;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd33;

  localparam logic [7:0]  CHAR_NULL    = 8'd0;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [15:0] CHAR_ADVANCE = 16'd8;

  typedef enum logic [1:0] {
    KIND_FONT_WRITE = 2'd0,
    KIND_START      = 2'd1,
    KIND_CHAR       = 2'd2
  } bftr_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bftr_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bftr_state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [11:0]       font_addr;
    logic [7:0]        font_data;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]        char_code;
    logic [31:0]       text_color;
  } bftr_in_t;

  typedef struct packed {
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [7:0]        pixel_mask;
    logic [31:0]       pixel_color;
    logic              last_row;
  } bftr_out_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
  } bftr_row_req_t;

endpackage

`default_nettype wire

@@ rtl/core/bftr_stream_if.sv @@
// Valid/ready stream channel carrying one payload item
`default_nettype none

interface bftr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bftr_font_mem.sv @@
// Single-port font memory with registered read data
`default_nettype none

module bftr_font_mem import bftr_pkg::*; #(
  parameter int FONT_DEPTH = DEF_FONT_DEPTH,
  localparam int AW = $clog2(FONT_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bftr_seq.sv @@
// Item sequencer: cursor state, font writes and glyph row reads
`default_nettype none

module bftr_seq import bftr_pkg::*; #(
  parameter int GLYPH_ROWS = DEF_GLYPH_ROWS,
  parameter int FONT_DEPTH = DEF_FONT_DEPTH,
  localparam int AW = $clog2(FONT_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  bftr_stream_if.sink        items,
  input  wire logic          slot_free,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [7:0]         mem_wdata,
  output bftr_row_req_t      req
);

  localparam int CW        = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int RAW_W     = 8 + $clog2(GLYPH_ROWS);
  localparam int MOD_STEPS = $clog2((256 * GLYPH_ROWS + FONT_DEPTH - 1) / FONT_DEPTH);
  localparam int CMP_W     = ((AW > FONT_ADDR_W) ? AW : FONT_ADDR_W) + 1;

  bftr_state_t  state;
  bftr_state_t  state_next;
  logic [15:0]  cursor_x;
  logic [15:0]  cursor_y;
  logic [15:0]  line_x;
  logic [31:0]  color;
  logic [15:0]  glyph_x;
  logic [15:0]  glyph_y;
  logic [31:0]  glyph_color;
  logic [CW-1:0] row;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_next;
  logic [AW-1:0] base_addr;
  logic [RAW_W-1:0] raw_addr;
  logic [RAW_W-1:0] rem;
  logic         wr_ok;
  logic         row_last;
  logic         do_start;
  logic         do_newline;
  logic         do_glyph;
  logic         do_row;

  assign raw_addr = RAW_W'(items.payload.char_code) * RAW_W'(GLYPH_ROWS);

  always_comb begin
    rem = raw_addr;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (rem >= RAW_W'(FONT_DEPTH << k)) begin
        rem = rem - RAW_W'(FONT_DEPTH << k);
      end
    end
    base_addr = AW'(rem);
  end

  assign wr_ok        = CMP_W'(items.payload.font_addr) < CMP_W'(FONT_DEPTH);
  assign row_last     = row == CW'(GLYPH_ROWS - 1);
  assign rd_addr_next = (rd_addr == AW'(FONT_DEPTH - 1)) ? '0 : rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = rd_addr;
    mem_wdata   = items.payload.font_data;
    do_start    = 1'b0;
    do_newline  = 1'b0;
    do_glyph    = 1'b0;
    do_row      = 1'b0;
    req.valid   = 1'b0;
    req.last    = row_last;
    req.x       = glyph_x;
    req.y       = glyph_y + 16'(row);
    req.color   = glyph_color;
    case (state)
      ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          case (items.payload.kind)
            KIND_FONT_WRITE: begin
              if (wr_ok) begin
                mem_we   = 1'b1;
                mem_addr = AW'(items.payload.font_addr);
              end
            end
            KIND_START: do_start = 1'b1;
            KIND_CHAR: begin
              if (items.payload.char_code == CHAR_NEWLINE) begin
                do_newline = 1'b1;
              end else if (items.payload.char_code != CHAR_NULL) begin
                do_glyph   = 1'b1;
                state_next = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          mem_re    = 1'b1;
          do_row    = 1'b1;
          req.valid = 1'b1;
          if (row_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      line_x   <= '0;
      color    <= '0;
    end else begin
      if (do_start) begin
        cursor_x <= items.payload.start_x;
        cursor_y <= items.payload.start_y;
        line_x   <= items.payload.start_x;
        color    <= items.payload.text_color;
      end
      if (do_newline) begin
        cursor_y <= cursor_y + 16'(GLYPH_ROWS);
        cursor_x <= line_x;
      end
      if (do_glyph) begin
        cursor_x <= cursor_x + CHAR_ADVANCE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_glyph) begin
      glyph_x     <= cursor_x;
      glyph_y     <= cursor_y;
      glyph_color <= color;
      rd_addr     <= base_addr;
      row         <= '0;
    end else if (do_row) begin
      rd_addr <= rd_addr_next;
      row     <= row + CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bftr_row_out.sv @@
// Frame clipping, frame size registers and the result register
`default_nettype none

module bftr_row_out import bftr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire bftr_row_req_t         req,
  input  wire logic [7:0]            rdata,
  output logic                       slot_free,
  bftr_stream_if.source              rows
);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  pend_valid;
  bftr_row_req_t         pend;
  logic                  take;
  logic                  out_valid;
  bftr_out_t             out_payload;
  logic                  row_in;
  logic [16:0]           col;
  logic [7:0]            clip_mask;

  assign take      = pend_valid && (!out_valid || rows.ready);
  assign slot_free = !pend_valid || take;
  assign row_in    = !pend.y[15] && (pend.y < 16'(frame_height));

  always_comb begin
    col       = '0;
    clip_mask = '0;
    for (int j = 0; j < 8; j++) begin
      col = {pend.x[15], pend.x} + 17'(j);
      clip_mask[7 - j] = row_in && !col[16] && (col < 17'(frame_width));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req.valid) begin
        pend_valid <= 1'b1;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (rows.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      pend <= req;
    end
    if (take) begin
      out_payload.row_x       <= pend.x;
      out_payload.row_y       <= pend.y;
      out_payload.pixel_mask  <= rdata & clip_mask;
      out_payload.pixel_color <= pend.color;
      out_payload.last_row    <= pend.last;
    end
  end

  assign rows.valid   = out_valid;
  assign rows.payload = out_payload;

endmodule

`default_nettype wire

@@ rtl/core/bitmap_font_text_renderer_top.sv @@
// Top level of the 8x16 bitmap font text renderer
// A drawn character sends the sequencer to its run state, with one font memory read per glyph
//   row on the single memory port; rows pass the pending and then the result register.
//   New items wait until all its rows are requested; other items leave the input ready.
// Reset: synchronous rst clears cursor, line start and colour, sets the frame to 130x33
//   and empties the row pipeline; the font memory keeps its contents and is not swept.
`default_nettype none

module bitmap_font_text_renderer_top import bftr_pkg::*; #(
  parameter int GLYPH_ROWS = DEF_GLYPH_ROWS,
  parameter int FONT_DEPTH = DEF_FONT_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bftr_stream_if.sink                items,
  bftr_stream_if.source              rows,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FONT_DEPTH);

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic          slot_free;
  bftr_row_req_t req;

  bftr_seq #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .FONT_DEPTH (FONT_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .slot_free (slot_free),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .req       (req)
  );

  bftr_font_mem #(
    .FONT_DEPTH (FONT_DEPTH)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bftr_row_out u_row_out (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rdata     (mem_rdata),
    .slot_free (slot_free),
    .rows      (rows)
  );

endmodule

`default_nettype wire

@@ rtl/core/bftr_checker.sv @@
// Port-level assertions of the text renderer and their binding
`default_nettype none

`include "bitmap_font_text_renderer_top_macros.svh"

module bftr_checker import bftr_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_kind,
  input wire logic [7:0] in_code,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire bftr_out_t  out_payload
);

  `BFTR_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && in_ready, "not idle after reset")

  `BFTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled row changed")

  `BFTR_ASSERT_NEXT(a_glyph_busy, in_valid && in_ready && in_kind == KIND_CHAR && in_code != CHAR_NEWLINE && in_code != CHAR_NULL, !in_ready, "ready during glyph")

  `BFTR_ASSERT_NEXT(a_short_item, in_valid && in_ready && in_kind != KIND_CHAR, in_ready, "ready dropped after short item")

endmodule

bind bitmap_font_text_renderer_top bftr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_kind     (items.payload.kind),
  .in_code     (items.payload.char_code),
  .out_valid   (rows.valid),
  .out_ready   (rows.ready),
  .out_payload (rows.payload)
);

`default_nettype wire

@@ tb/tb_bitmap_font_text_renderer_top.sv @@
// Self-checking testbench for the bitmap font text renderer top level
`default_nettype none

module tb_bitmap_font_text_renderer_top;
  import bftr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 35;
  localparam int NUM_PHASES = 8;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [7:0]  code;
    logic [31:0] color;
    bit          typed;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [7:0]  tmask;
    logic [31:0] tcolor;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bftr_stream_if #(.payload_t(bftr_in_t))  items_if ();
  bftr_stream_if #(.payload_t(bftr_out_t)) rows_if ();

  bitmap_font_text_renderer_top dut (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .rows(rows_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  font_bytes [DEF_FONT_DEPTH];
  logic [7:0]  glyph_codes [$];
  bftr_out_t   pending_rows [$];
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic [15:0] line_x = '0;
  logic [31:0] cur_color = '0;
  int frame_w = int'(FRAME_WIDTH_RESET);
  int frame_h = int'(FRAME_HEIGHT_RESET);

  int items_sent = 0;
  int rows_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bftr_out_t got_row;
  bftr_out_t want_row;

  function automatic void render_item(bftr_in_t it, bit keep);
    bftr_out_t r;
    int x, y, c, a;
    logic [15:0] ry;
    logic [7:0] m;
    case (it.kind)
      KIND_FONT_WRITE: begin
        font_bytes[it.font_addr] = it.font_data;
      end
      KIND_START: begin
        cur_x = it.start_x;
        cur_y = it.start_y;
        line_x = it.start_x;
        cur_color = it.text_color;
      end
      KIND_CHAR: begin
        if (it.char_code == CHAR_NEWLINE) begin
          cur_y = cur_y + 16'(DEF_GLYPH_ROWS);
          cur_x = line_x;
        end else if (it.char_code != CHAR_NULL) begin
          x = int'($signed(cur_x));
          for (int i = 0; i < DEF_GLYPH_ROWS; i++) begin
            ry = cur_y + 16'(i);
            y = int'($signed(ry));
            a = (it.char_code * DEF_GLYPH_ROWS + i) % DEF_FONT_DEPTH;
            m = '0;
            for (int j = 0; j < 8; j++) begin
              c = x + j;
              if (y >= 0 && y < frame_h && c >= 0 && c < frame_w) m[7-j] = 1'b1;
            end
            r.row_x = cur_x;
            r.row_y = ry;
            r.pixel_mask = font_bytes[a] & m;
            r.pixel_color = cur_color;
            r.last_row = (i == DEF_GLYPH_ROWS - 1);
            if (keep) pending_rows.push_back(r);
          end
          cur_x = cur_x + CHAR_ADVANCE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bftr_in_t noise();
    bftr_in_t n;
    n.kind = 2'($urandom);
    n.font_addr = 12'($urandom);
    n.font_data = 8'($urandom);
    n.start_x = 16'($urandom);
    n.start_y = 16'($urandom);
    n.char_code = 8'($urandom);
    n.text_color = $urandom;
    return n;
  endfunction

  function automatic void match(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic offer_item(input bftr_in_t it, input bit predicted);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    items_if.valid <= 1'b1;
    items_if.payload <= it;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    render_item(it, predicted);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic load_glyph(input logic [7:0] code, input int style);
    bftr_in_t it;
    bit known;
    for (int i = 0; i < DEF_GLYPH_ROWS; i++) begin
      it = noise();
      it.kind = KIND_FONT_WRITE;
      it.font_addr = {code, i[3:0]};
      case (style)
        0: it.font_data = 8'hff;
        1: it.font_data = 8'h80 >> (i % 8);
        2: it.font_data = i[0] ? 8'h55 : 8'haa;
        default: ;
      endcase
      offer_item(it, 1'b1);
    end
    known = 1'b0;
    foreach (glyph_codes[k]) if (glyph_codes[k] == code) known = 1'b1;
    if (!known) glyph_codes.push_back(code);
  endtask

  task automatic settle();
    items_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input bftr_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_FRAME_WIDTH) frame_w = int'(value);
    else frame_h = int'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  step_t steps [27] = '{
    '{KIND_FONT_WRITE, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h00, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_FONT_WRITE, 12'hfff, 8'hff, 16'h7fff, 16'h8000, 8'h0a, 32'hffffffff,
      0, 0, 0, 0, 0},
    '{KIND_UNUSED, 12'h123, 8'h5a, 16'h0040, 16'h0040, 8'h41, 32'h13579bdf, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0,
      1, 16'h0000, 16'h0000, 8'hff, 32'h0},
    '{KIND_START, 12'hfff, 8'hff, 16'd126, 16'd0, 8'hff, 32'hffffffff, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0,
      1, 16'd126, 16'd0, 8'hf0, 32'hffffffff},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0,
      1, 16'd134, 16'd0, 8'h00, 32'hffffffff},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h0a, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0,
      1, 16'd126, 16'd16, 8'hf0, 32'hffffffff},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h0a, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h00, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_START, 12'h000, 8'h00, 16'h8000, 16'h8000, 8'h00, 32'h12345678, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h01, 32'h0,
      1, 16'h8000, 16'h8000, 8'h00, 32'h12345678},
    '{KIND_START, 12'h000, 8'h00, 16'h7fff, 16'h7fff, 8'h00, 32'h80000000, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h80, 32'h0,
      1, 16'h7fff, 16'h7fff, 8'h00, 32'h80000000},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_START, 12'h000, 8'h00, 16'hfffc, 16'hffff, 8'h00, 32'ha5a5a5a5, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h01, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h0a, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h80, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_START, 12'h000, 8'h00, 16'd0, 16'd17, 8'h00, 32'h0000ffff, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'hff, 32'h0,
      1, 16'd0, 16'd17, 8'hff, 32'h0000ffff},
    '{KIND_FONT_WRITE, 12'h010, 8'h81, 16'h1234, 16'h4321, 8'hff, 32'hdeadbeef,
      0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h7f, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_CHAR, 12'h000, 8'h00, 16'h0000, 16'h0000, 8'h01, 32'h0, 0, 0, 0, 0, 0}
  };

  int phase_w [NUM_PHASES] = '{4096, 1, 0, 8191, 40, 8191, 0, 130};
  int phase_h [NUM_PHASES] = '{4096, 1, 0, 8191, 24, 1, 4096, 33};

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_font_text_renderer_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rows_if.valid === 1'b1 && rows_if.ready === 1'b1) begin
      got_row = rows_if.payload;
      if (pending_rows.size() == 0) begin
        $error("row with nothing pending: x %h y %h mask %h",
               got_row.row_x, got_row.row_y, got_row.pixel_mask);
        mismatches++;
      end else begin
        want_row = pending_rows.pop_front();
        match("row_x", 32'(want_row.row_x), 32'(got_row.row_x));
        match("row_y", 32'(want_row.row_y), 32'(got_row.row_y));
        match("pixel_mask", 32'(want_row.pixel_mask), 32'(got_row.pixel_mask));
        match("pixel_color", want_row.pixel_color, got_row.pixel_color);
        match("last_row", 32'(want_row.last_row), 32'(got_row.last_row));
      end
      rows_seen++;
    end
  end

  initial begin : row_sink
    int mode;
    int span;
    bit held;
    held = 1'b0;
    rows_if.ready = 1'b0;
    forever begin
      if (!held && rows_seen >= 300) begin
        held = 1'b1;
        rows_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          0: rows_if.ready <= 1'b1;
          1: rows_if.ready <= 1'($urandom_range(0, 1));
          default: rows_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    bftr_in_t it;
    bftr_out_t exp_row;
    int phase_items;
    int pick;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.payload = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_glyph(8'hff, 0);
    load_glyph(8'h01, 1);
    load_glyph(8'h80, 2);
    load_glyph(8'h7f, 3);

    foreach (steps[k]) begin
      it.kind = steps[k].kind;
      it.font_addr = steps[k].addr;
      it.font_data = steps[k].data;
      it.start_x = steps[k].sx;
      it.start_y = steps[k].sy;
      it.char_code = steps[k].code;
      it.text_color = steps[k].color;
      offer_item(it, !steps[k].typed);
      if (steps[k].typed) begin
        for (int i = 0; i < DEF_GLYPH_ROWS; i++) begin
          exp_row.row_x = steps[k].tx;
          exp_row.row_y = steps[k].ty + 16'(i);
          exp_row.pixel_mask = steps[k].tmask;
          exp_row.pixel_color = steps[k].tcolor;
          exp_row.last_row = (i == DEF_GLYPH_ROWS - 1);
          pending_rows.push_back(exp_row);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p >= NUM_PHASES - 2 && $urandom_range(0, 1) == 1) begin
        write_cfg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 300)));
        write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 300)));
      end else begin
        write_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(phase_w[p]));
        write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(phase_h[p]));
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        it = noise();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          load_glyph(8'($urandom_range(1, 255)), 3);
          phase_items += DEF_GLYPH_ROWS;
        end else begin
          if (pick < 12) begin
            it.kind = KIND_FONT_WRITE;
          end else if (pick < 24) begin
            it.kind = KIND_START;
            if ($urandom_range(0, 3) != 0) begin
              it.start_x = 16'($urandom_range(0, frame_w + 24) - 16);
              it.start_y = 16'($urandom_range(0, frame_h + 20) - 18);
            end
          end else if (pick < 33) begin
            it.kind = KIND_CHAR;
            it.char_code = CHAR_NEWLINE;
          end else if (pick < 37) begin
            it.kind = KIND_CHAR;
            it.char_code = CHAR_NULL;
          end else if (pick < 40) begin
            it.kind = KIND_UNUSED;
          end else begin
            it.kind = KIND_CHAR;
            it.char_code = glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
          end
          offer_item(it, 1'b1);
          phase_items++;
        end
      end
    end

    settle();
    if (pending_rows.size() != 0) begin
      $error("%0d rows never arrived", pending_rows.size());
      mismatches++;
    end
    $display("covered %0d items and %0d glyph rows over %0d frame sizes, %0d glyphs loaded",
             items_sent, rows_seen, NUM_PHASES + 1, glyph_codes.size());
    $display("found %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("bitmap_font_text_renderer_top test passed");
    end else begin
      $display("bitmap_font_text_renderer_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
